/* sv/spq_pkg.sv */
`default_nettype none
package spq_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned ID_W         = 16;
    localparam int unsigned KEY_W        = 32;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic                    action;
        logic [ID_W-1:0]         entry_id;
        logic signed [KEY_W-1:0] entry_key;
    } t_in_beat;

    typedef struct packed {
        logic [ID_W-1:0] removed_id;
        t_status         status;
        logic            now_empty;
    } t_out_beat;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [KEY_W-1:0] key;
    } t_entry;

    // Chain-wide command for one cycle.
    typedef struct packed {
        logic shift_in;   // insert: open a slot and place the new entry
        logic shift_out;  // remove: everything moves one cell toward the head
    } t_cell_ctl;

endpackage
`default_nettype wire

/* sv/sorted_priority_queue_top.sv */
// Sorted min-priority queue built as a row of entry cells.
// The result beat appears in the cycle after the input beat is taken.
// Throughput: one insert or remove per cycle unless the output stalls; every
// cell updates in parallel; each cell's compare to the new key sets cycle time.
// Reset (synchronous, active low) empties the queue and drops the output valid.
`default_nettype none
module sorted_priority_queue_top #(
    parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire spq_pkg::t_in_beat i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output spq_pkg::t_out_beat     o_out_data
);
    import spq_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out_beat        r_out_data;
    t_out_beat        n_out_data;

    logic      accept;
    logic      is_full;
    logic      is_empty;
    t_cell_ctl ctl;
    t_entry    new_entry;
    t_entry    cell_entry [CAPACITY];
    logic      cell_push  [CAPACITY];

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);

    assign new_entry.id  = i_in_data.entry_id;
    assign new_entry.key = i_in_data.entry_key;

    assign ctl.shift_in  = accept && (i_in_data.action == ACT_INSERT) && !is_full;
    assign ctl.shift_out = accept && (i_in_data.action == ACT_REMOVE) && !is_empty;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry left_entry;
        t_entry right_entry;
        logic   left_push;
        logic   valid;

        assign valid = (r_count > CNT_W'(g));

        if (g == 0) begin : g_head
            assign left_entry = new_entry;
            assign left_push  = 1'b0;
        end else begin : g_body
            assign left_entry = cell_entry[g-1];
            assign left_push  = cell_push[g-1];
        end

        // The tail takes filler on a remove; the count marks it free anyway.
        if (g == CAPACITY - 1) begin : g_tail
            assign right_entry = cell_entry[g];
        end else begin : g_mid
            assign right_entry = cell_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_new       (new_entry),
            .i_left      (left_entry),
            .i_right     (right_entry),
            .i_left_push (left_push),
            .i_valid     (valid),
            .o_entry     (cell_entry[g]),
            .o_push      (cell_push[g])
        );
    end

    always_comb begin
        n_count               = r_count;
        n_out_data.removed_id = '0;
        n_out_data.status     = ST_OK;
        n_out_data.now_empty  = 1'b0;
        unique case (i_in_data.action)
            ACT_INSERT: begin
                if (is_full) begin
                    n_out_data.status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_REMOVE: begin
                if (is_empty) begin
                    n_out_data.status    = ST_EMPTY;
                    n_out_data.now_empty = 1'b1;
                end else begin
                    n_count               = r_count - CNT_W'(1);
                    n_out_data.removed_id = cell_entry[0].id;
                    n_out_data.now_empty  = (r_count == CNT_W'(1));
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result beat until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
`default_nettype wire

/* sv/spq_cell.sv */
`default_nettype none
module spq_cell (
    input  wire logic              i_clk,
    input  wire spq_pkg::t_cell_ctl i_ctl,
    input  wire spq_pkg::t_entry   i_new,
    input  wire spq_pkg::t_entry   i_left,
    input  wire spq_pkg::t_entry   i_right,
    input  wire logic              i_left_push,
    input  wire logic              i_valid,
    output spq_pkg::t_entry        o_entry,
    output logic                   o_push
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Push when this slot is free or holds a key not below the new one,
    // so the new entry lands ahead of equal keys.
    assign o_push  = !i_valid || (r_entry.key >= i_new.key);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.shift_out) begin
            n_entry = i_right;
        end else if (i_ctl.shift_in && o_push) begin
            n_entry = i_left_push ? i_left : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire
